>>> design/wsfd_pkg.sv
package wsfd_pkg;

    localparam int LEN_BITS = 64;
    localparam int APB_ADDR_W = 2;
    localparam int MASK_BYTES = 4;

    localparam logic [7:0] FIRST_BYTE = 8'd129;
    localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;
    localparam logic [1:0] MASK_LAST = 2'd3;

    localparam logic [APB_ADDR_W-1:0] REG_MAX_FRAME = APB_ADDR_W'(0);
    localparam logic [31:0] MAX_FRAME_RESET = 32'd16384;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_LEN,
        PH_EXT,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA,
        ST_EMPTY,
        ST_BAD,
        ST_OVERSIZE
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        status_t    status;
    } beat_t;

endpackage

>>> design/wsfd_if.sv
interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output data_byte, output last, output status, input ready);
    modport sink (input valid, input data_byte, input last, input status, output ready);
endinterface

>>> design/wsfd_parser.sv
module wsfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic [31:0]       max_frame_bytes,
    output logic              res_valid,
    output wsfd_pkg::beat_t   res
);
    import wsfd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [2:0]          ext_cnt_reg, ext_cnt_next;
    logic [1:0]          mask_cnt_reg, mask_cnt_next;
    logic                drop_reg, drop_next;
    logic                bad_reg, bad_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [31:0]         key_reg, key_next;
    logic [3:0]          hdr_reg, hdr_next;

    logic [63:0]         len64;
    logic [32:0]         low_total;
    logic                oversize;
    logic [7:0]          unmasked;

    assign len64 = 64'(len_reg);
    assign low_total = {1'b0, len64[31:0]} + 33'(hdr_reg) + 33'(MASK_BYTES);
    assign oversize = (|len64[63:32]) || (low_total >= {1'b0, max_frame_bytes});
    assign unmasked = in_byte ^ key_reg[31:24];

    always_comb
    begin
        phase_next = phase_reg;
        ext_cnt_next = ext_cnt_reg;
        mask_cnt_next = mask_cnt_reg;
        drop_next = drop_reg;
        bad_next = bad_reg;
        len_next = len_reg;
        rem_next = rem_reg;
        key_next = key_reg;
        hdr_next = hdr_reg;
        res_valid = 1'b0;
        res = '{data_byte: 8'd0, last: 1'b0, status: ST_DATA};
        if (accept)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    bad_next = (in_byte != FIRST_BYTE);
                    hdr_next = 4'd1;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (bad_reg)
                    begin
                        phase_next = PH_FIRST;
                        bad_next = 1'b0;
                        res_valid = 1'b1;
                        res = '{data_byte: 8'd0, last: 1'b1, status: ST_BAD};
                    end
                    else
                    begin
                        hdr_next = 4'd2;
                        if (in_byte[6:0] <= LEN7_MAX_SHORT)
                        begin
                            len_next = LEN_BITS'(in_byte[6:0]);
                            phase_next = PH_MASK;
                        end
                        else
                        begin
                            len_next = '0;
                            ext_cnt_next = (in_byte[6:0] == LEN7_EXT16) ? EXT16_LEFT
                                                                         : EXT64_LEFT;
                            phase_next = PH_EXT;
                        end
                    end
                end
                PH_EXT:
                begin
                    len_next = {len_reg[LEN_BITS-9:0], in_byte};
                    hdr_next = 4'(hdr_reg + 4'd1);
                    ext_cnt_next = 3'(ext_cnt_reg - 3'd1);
                    if (ext_cnt_reg == 3'd0)
                        phase_next = PH_MASK;
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    if (mask_cnt_reg != MASK_LAST)
                        mask_cnt_next = 2'(mask_cnt_reg + 2'd1);
                    else
                    begin
                        mask_cnt_next = 2'd0;
                        if (len_reg == '0)
                        begin
                            phase_next = PH_FIRST;
                            drop_next = 1'b0;
                            res_valid = 1'b1;
                            res = '{data_byte: 8'd0, last: 1'b1,
                                    status: oversize ? ST_OVERSIZE : ST_EMPTY};
                        end
                        else
                        begin
                            drop_next = oversize;
                            rem_next = len_reg;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    key_next = {key_reg[23:0], key_reg[31:24]};
                    if (rem_reg == LEN_BITS'(1))
                    begin
                        phase_next = PH_FIRST;
                        drop_next = 1'b0;
                        res_valid = 1'b1;
                        if (drop_reg)
                            res = '{data_byte: 8'd0, last: 1'b1, status: ST_OVERSIZE};
                        else
                            res = '{data_byte: unmasked, last: 1'b1, status: ST_DATA};
                    end
                    else
                    begin
                        rem_next = rem_reg - LEN_BITS'(1);
                        res_valid = !drop_reg;
                        res = '{data_byte: unmasked, last: 1'b0, status: ST_DATA};
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                    ext_cnt_next = 3'd0;
                    mask_cnt_next = 2'd0;
                    drop_next = 1'b0;
                    bad_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            ext_cnt_reg <= 3'd0;
            mask_cnt_reg <= 2'd0;
            drop_reg <= 1'b0;
            bad_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            ext_cnt_reg <= ext_cnt_next;
            mask_cnt_reg <= mask_cnt_next;
            drop_reg <= drop_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        rem_reg <= rem_next;
        key_reg <= key_next;
        hdr_reg <= hdr_next;
    end

endmodule

>>> design/wsfd_skid.sv
module wsfd_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wsfd_pkg::beat_t push_beat,
    output logic            space,
    output logic            out_valid,
    input  logic            out_ready,
    output wsfd_pkg::beat_t out_beat
);
    import wsfd_pkg::*;

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    beat_t main_reg, main_next;
    beat_t skid_reg, skid_next;
    logic  pop;

    assign pop = main_valid_reg && out_ready;
    assign space = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_beat = main_reg;

    // skid slot only fills while the main slot holds a stalled beat
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next = main_reg;
        skid_next = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                main_next = push_beat;
            else
                main_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_next = push_beat;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next = push_beat;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> design/websocket_frame_deframer.sv
// WebSocket frame deframer.
// stream (sink): one received byte per beat, in_byte. payload (source): one
// result beat with data_byte, last and status (0 payload byte, 1 empty frame,
// 2 bad first byte, 3 oversize frame dropped). Header, length and mask-key
// bytes give no beat, save the last mask-key byte of an empty frame; a bad
// first byte gives one beat on the byte after it. Results are registered in
// the output register. Throughput: one byte per cycle while stream.ready is
// high, set by the header state machine and unmasking path feeding it.
// Stall: a two-entry output register (main plus skid) keeps stream.ready high
// while one result waits; stream.ready drops only when both entries are full.
// Reset (rst_n low, asynchronous): parser returns to expecting the first
// header byte, output entries are emptied and max_frame_bytes returns to 16384.
// APB: max_frame_bytes at address 0, write only while the block is idle.
// pready is tied high; reads return the register, other addresses read zero.
module websocket_frame_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    wsfd_in_if.sink                         stream,
    wsfd_out_if.source                      payload,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import wsfd_pkg::*;

    logic [31:0] max_frame_reg;
    logic        accept;
    logic        res_valid;
    beat_t       res;
    beat_t       out_beat;
    logic        space;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_FRAME) ? max_frame_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_reg <= MAX_FRAME_RESET;
        else if (psel && penable && pwrite && (paddr == REG_MAX_FRAME))
            max_frame_reg <= pwdata;
    end

    assign stream.ready = space;
    assign accept = stream.valid && space;

    wsfd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .in_byte         (stream.in_byte),
        .max_frame_bytes (max_frame_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    wsfd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_beat (res),
        .space     (space),
        .out_valid (payload.valid),
        .out_ready (payload.ready),
        .out_beat  (out_beat)
    );

    assign payload.data_byte = out_beat.data_byte;
    assign payload.last = out_beat.last;
    assign payload.status = out_beat.status;

`ifndef SYNTHESIS
    a_res_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (stream.valid && stream.ready))
        else $error("result without an accepted beat");

    a_stall_only_when_backed_up: assert property (@(posedge clk) disable iff (!rst_n)
        !stream.ready |-> payload.valid)
        else $error("input stalled with output empty");

    a_event_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != ST_DATA)) |-> (res.last && (res.data_byte == 8'd0)))
        else $error("status event not marked last or data not zero");
`endif

endmodule

>>> bench/websocket_frame_deframer_check.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_check (
    input  logic                            clk,
    input  logic                            rst_n,
    wsfd_in_if                              stream,
    wsfd_out_if                             payload,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    output int                              error_count,
    output int                              beats_owed
);
    import wsfd_pkg::*;

    localparam int EXT16_BYTES = 2;
    localparam int EXT64_BYTES = 8;

    logic [31:0] frame_limit;
    phase_t      ph;
    int          ext_left;
    logic [63:0] plen;
    logic [31:0] key;
    logic [1:0]  key_cnt;
    logic [63:0] pidx;
    logic [3:0]  hdr_cnt;
    logic        drop;
    logic        bad;

    beat_t frame_beats_q[$];
    int    mismatches;

    function automatic beat_t make_beat(input logic [7:0] d, input logic l, input status_t s);
        beat_t r;
        r.data_byte = d;
        r.last = l;
        r.status = s;
        return r;
    endfunction

    task automatic restart_frame();
        ph = PH_FIRST;
        ext_left = 0;
        plen = '0;
        key = '0;
        key_cnt = '0;
        pidx = '0;
        hdr_cnt = '0;
        drop = 1'b0;
        bad = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [63:0] hdr;
        logic [63:0] total;
        logic [7:0]  kb;
        logic        dropped;
        logic        is_last;
        case (ph)
            PH_FIRST:
            begin
                bad = (b != FIRST_BYTE);
                hdr_cnt = 4'd1;
                ph = PH_LEN;
            end
            PH_LEN:
            begin
                if (bad)
                begin
                    restart_frame();
                    frame_beats_q.push_back(make_beat(8'd0, 1'b1, ST_BAD));
                end
                else
                begin
                    hdr_cnt = 4'd2;
                    plen = '0;
                    if (b[6:0] <= LEN7_MAX_SHORT)
                    begin
                        plen = 64'(b[6:0]);
                        ph = PH_MASK;
                    end
                    else
                    begin
                        ext_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        ph = PH_EXT;
                    end
                end
            end
            PH_EXT:
            begin
                plen = {plen[55:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                ext_left = ext_left - 1;
                if (ext_left == 0)
                    ph = PH_MASK;
            end
            PH_MASK:
            begin
                key = {key[23:0], b};
                if (key_cnt < MASK_LAST)
                    key_cnt = key_cnt + 2'd1;
                else
                begin
                    key_cnt = '0;
                    hdr = 64'(hdr_cnt) + 64'd4;
                    total = (plen > ~64'd0 - hdr) ? ~64'd0 : plen + hdr;
                    drop = (total >= 64'(frame_limit));
                    pidx = '0;
                    if (plen == 64'd0)
                    begin
                        dropped = drop;
                        restart_frame();
                        frame_beats_q.push_back(make_beat(8'd0, 1'b1,
                            dropped ? ST_OVERSIZE : ST_EMPTY));
                    end
                    else
                        ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                kb = 8'(key >> ((3 - int'(pidx[1:0])) * 8));
                is_last = (pidx >= plen - 64'd1);
                dropped = drop;
                if (is_last)
                begin
                    restart_frame();
                    if (dropped)
                        frame_beats_q.push_back(make_beat(8'd0, 1'b1, ST_OVERSIZE));
                    else
                        frame_beats_q.push_back(make_beat(b ^ kb, 1'b1, ST_DATA));
                end
                else
                begin
                    pidx = pidx + 64'd1;
                    if (!dropped)
                        frame_beats_q.push_back(make_beat(b ^ kb, 1'b0, ST_DATA));
                end
            end
            default:
                restart_frame();
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t want;
        if (!rst_n)
        begin
            frame_limit = MAX_FRAME_RESET;
            restart_frame();
            frame_beats_q.delete();
            mismatches = 0;
            beats_owed <= 0;
            error_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_MAX_FRAME)
                frame_limit = pwdata;
            // outgoing beat first: a byte taken at this edge cannot have produced it
            if (payload.valid && payload.ready)
            begin
                if (frame_beats_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected beat: data_byte %02h last %0d status %0d",
                        $time, payload.data_byte, payload.last, payload.status);
                end
                else
                begin
                    want = frame_beats_q.pop_front();
                    if (payload.data_byte !== want.data_byte || payload.last !== want.last
                        || payload.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: expected data_byte %02h last %0d status %0d, got %02h %0d %0d",
                            $time, want.data_byte, want.last, want.status,
                            payload.data_byte, payload.last, payload.status);
                    end
                end
            end
            if (stream.valid && stream.ready)
                parse_byte(stream.in_byte);
            beats_owed <= frame_beats_q.size();
            error_count <= mismatches;
        end
    end

endmodule

>>> bench/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
    import wsfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int error_count;
    int beats_owed;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_reqs;
    int bytes_sent;
    int cycles;

    wsfd_in_if  stream_if();
    wsfd_out_if payload_if();

    websocket_frame_deframer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .payload (payload_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    websocket_frame_deframer_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_if),
        .payload     (payload_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .error_count (error_count),
        .beats_owed  (beats_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin : watchdog
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver; a long hold-off is counted here when one is requested
    initial
    begin : rx_side
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        payload_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_reqs)
            begin
                holds_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                payload_if.ready <= 1'b0;
            end
            else
                payload_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            stream_if.valid <= 1'b0;
            stream_if.in_byte <= 8'($urandom);
            @(posedge clk);
        end
        stream_if.valid <= 1'b1;
        stream_if.in_byte <= b;
        do @(posedge clk); while (!stream_if.ready);
        bytes_sent++;
    endtask

    task automatic send_key(input logic [31:0] k);
        for (int i = 0; i < 4; i++)
            send_byte(k[31 - 8*i -: 8]);
    endtask

    task automatic send_frame(input int max_len);
        int          pick;
        int          len;
        logic        mflag;
        logic [7:0]  b;
        pick = $urandom_range(99);
        mflag = 1'($urandom);
        if (pick < 8)
        begin
            // broken pair: near miss or random first byte
            b = (pick < 4) ? FIRST_BYTE ^ (8'd1 << $urandom_range(7)) : 8'($urandom);
            if (b == FIRST_BYTE)
                b = ~b;
            send_byte(b);
            send_byte(8'($urandom));
            return;
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(max_len) : $urandom_range(8);
        send_byte(FIRST_BYTE);
        if (pick < 75 && len <= int'(LEN7_MAX_SHORT))
            send_byte({mflag, 7'(len)});
        else if (pick < 90)
        begin
            send_byte({mflag, LEN7_EXT16});
            send_byte(8'(len >> 8));
            send_byte(8'(len));
        end
        else
        begin
            send_byte({mflag, LEN7_EXT64});
            for (int i = 0; i < 6; i++)
                send_byte(8'd0);
            send_byte(8'(len >> 8));
            send_byte(8'(len));
        end
        send_key($urandom);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom));
    endtask

    task automatic wait_idle();
        stream_if.valid <= 1'b0;
        do @(posedge clk); while (beats_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MAX_FRAME;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] limit, input int budget, input int max_len);
        int start;
        wait_idle();
        write_limit(limit);
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_frame(max_len);
    endtask

    initial
    begin
        stream_if.valid <= 1'b0;
        stream_if.in_byte <= 8'd0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_MAX_FRAME;
        pwdata <= 32'd0;
        hold_reqs <= 0;
        bytes_sent = 0;
        tx_idle_pct = 10;
        rx_idle_pct = 83;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad first byte pair
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty frame, mask flag set
        send_byte(FIRST_BYTE);
        send_byte(8'h80);
        send_key(32'hAA55F00F);
        // one byte frame
        send_byte(FIRST_BYTE);
        send_byte(8'h01);
        send_key(32'hFF000000);
        send_byte(8'hFF);
        // 64-bit length
        send_byte(FIRST_BYTE);
        send_byte({1'b1, LEN7_EXT64});
        for (int i = 0; i < 7; i++)
            send_byte(8'h00);
        send_byte(8'h02);
        send_key(32'h01020408);
        send_byte(8'h00);
        send_byte(8'h7F);

        run_phase(32'hFFFFFFFF, 250, 130);
        run_phase(32'd0, 60, 20);
        tx_idle_pct = 83;
        rx_idle_pct = 10;
        run_phase(32'd1, 60, 20);
        run_phase(32'd30, 300, 40);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_idle();
        hold_reqs <= hold_reqs + 1;
        run_phase(32'd60, 250, 130);
        run_phase(MAX_FRAME_RESET, 250, 300);

        // length near 2^64: total saturates, so the frame is dropped silently
        send_byte(FIRST_BYTE);
        send_byte({1'b0, LEN7_EXT64});
        for (int i = 0; i < 8; i++)
            send_byte(8'hFF);
        send_key($urandom);
        for (int i = 0; i < 6; i++)
            send_byte(8'($urandom));

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
design/wsfd_pkg.sv
design/wsfd_if.sv
design/wsfd_parser.sv
design/wsfd_skid.sv
design/websocket_frame_deframer.sv
bench/websocket_frame_deframer_check.sv
bench/websocket_frame_deframer_tb.sv
